// File: sv/htok_pkg.sv
`default_nettype none

package htok_pkg;

    localparam int MAX_PARAMS_DEFAULT = 16;
    localparam int MAX_RESULTS        = 4;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [3:0] {
        ROLE_METHOD  = 4'd0,
        ROLE_PATH    = 4'd1,
        ROLE_KEY     = 4'd2,
        ROLE_VALUE   = 4'd3,
        ROLE_VERSION = 4'd4,
        ROLE_HEADER  = 4'd5,
        ROLE_BODY    = 4'd6,
        ROLE_DELIM   = 4'd7,
        ROLE_IGNORED = 4'd8
    } role_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } htok_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        role_t      role;
        logic [3:0] param_index;
        logic       token_start;
        logic       run_last;
        logic       message_done;
        logic       malformed;
    } htok_out_t;

    // all results caused by one request byte
    typedef struct packed {
        logic [2:0]                       count;
        htok_out_t [MAX_RESULTS-1:0]      res;
    } htok_bundle_t;

    typedef struct packed {
        logic         valid;
        htok_bundle_t bundle;
    } htok_push_t;

    typedef struct packed {
        logic         valid;
        htok_bundle_t bundle;
    } htok_head_t;

endpackage

`default_nettype wire

// File: sv/htok_front.sv
`default_nettype none

module htok_front
    import htok_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire htok_in_t   s_data,
    input  wire logic       q_full,
    output htok_push_t      push
);

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_QUERY   = 3'd2,
        PH_VERSION = 3'd3,
        PH_HEADER  = 3'd4,
        PH_BODY    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] b;
        role_t      role;
        logic [3:0] pidx;
    } raw_t;

    typedef struct packed {
        logic [2:0]                 n;
        raw_t [MAX_RESULTS-1:0]     item;
    } raw_list_t;

    localparam logic [4:0] SEG_LIMIT = 5'(MAX_PARAMS);

    phase_t     phase_reg, phase_next;
    logic [4:0] seg_reg, seg_next;
    logic       inval_reg, inval_next;
    logic [1:0] held_reg, held_next;
    logic       open_reg, open_next;

    raw_list_t    list;
    htok_bundle_t bundle;
    logic [7:0]   b;
    logic         last;
    logic         accept;
    logic         bad;
    role_t        flush_role;

    function automatic raw_list_t add(raw_list_t l, logic [7:0] vb, role_t r, logic [3:0] p);
        raw_list_t o;
        o = l;
        if (l.n < 3'(MAX_RESULTS)) begin
            o.item[l.n[1:0]] = '{b: vb, role: r, pidx: p};
            o.n = l.n + 3'd1;
        end
        return o;
    endfunction

    // byte k of the cr lf cr lf terminator
    function automatic logic [7:0] held_byte(logic [1:0] k);
        return k[0] ? CH_LF : CH_CR;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign last    = s_data.end_of_message;

    always_comb begin
        list       = '0;
        phase_next = phase_reg;
        seg_next   = seg_reg;
        inval_next = inval_reg;
        held_next  = held_reg;

        unique case (phase_reg)
            PH_METHOD: begin
                if (b == CH_SPACE) begin
                    list = add(list, b, ROLE_DELIM, 4'd0);
                    phase_next = PH_PATH;
                end else begin
                    list = add(list, b, ROLE_METHOD, 4'd0);
                end
            end
            PH_PATH: begin
                if (b == CH_SPACE) begin
                    list = add(list, b, ROLE_DELIM, 4'd0);
                    phase_next = PH_VERSION;
                end else if (b == CH_QMARK) begin
                    list = add(list, b, ROLE_DELIM, 4'd0);
                    phase_next = PH_QUERY;
                    seg_next   = '0;
                    inval_next = 1'b0;
                end else begin
                    list = add(list, b, ROLE_PATH, 4'd0);
                end
            end
            PH_QUERY: begin
                if (b == CH_SPACE) begin
                    list = add(list, b, ROLE_DELIM, 4'd0);
                    phase_next = PH_VERSION;
                end else if (seg_reg >= SEG_LIMIT) begin
                    list = add(list, b, ROLE_IGNORED, 4'd0);
                end else if (b == CH_AMP) begin
                    list = add(list, b, ROLE_DELIM, seg_reg[3:0]);
                    seg_next   = seg_reg + 5'd1;
                    inval_next = 1'b0;
                end else if (b == CH_EQ && !inval_reg) begin
                    list = add(list, b, ROLE_DELIM, seg_reg[3:0]);
                    inval_next = 1'b1;
                end else begin
                    list = add(list, b, inval_reg ? ROLE_VALUE : ROLE_KEY, seg_reg[3:0]);
                end
            end
            PH_VERSION: begin
                if (held_reg != 2'd0) begin
                    if (b == CH_LF) begin
                        list = add(list, CH_CR, ROLE_DELIM, 4'd0);
                        list = add(list, b, ROLE_DELIM, 4'd0);
                        held_next  = 2'd0;
                        phase_next = PH_HEADER;
                    end else begin
                        list = add(list, CH_CR, ROLE_VERSION, 4'd0);
                        if (b == CH_CR) begin
                            held_next = 2'd1;
                        end else begin
                            list = add(list, b, ROLE_VERSION, 4'd0);
                            held_next = 2'd0;
                        end
                    end
                end else if (b == CH_CR) begin
                    held_next = 2'd1;
                end else begin
                    list = add(list, b, ROLE_VERSION, 4'd0);
                end
            end
            PH_HEADER: begin
                if (b == held_byte(held_reg)) begin
                    if (held_reg == 2'd3) begin
                        for (int i = 0; i < 3; i++) begin
                            list = add(list, held_byte(2'(i)), ROLE_DELIM, 4'd0);
                        end
                        list = add(list, b, ROLE_DELIM, 4'd0);
                        held_next  = 2'd0;
                        phase_next = PH_BODY;
                    end else begin
                        held_next = held_reg + 2'd1;
                    end
                end else begin
                    // failed match: held bytes become header text
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < held_reg) begin
                            list = add(list, held_byte(2'(i)), ROLE_HEADER, 4'd0);
                        end
                    end
                    if (b == CH_CR) begin
                        held_next = 2'd1;
                    end else begin
                        list = add(list, b, ROLE_HEADER, 4'd0);
                        held_next = 2'd0;
                    end
                end
            end
            default: begin
                list = add(list, b, ROLE_BODY, 4'd0);
            end
        endcase

        flush_role = (phase_next == PH_VERSION) ? ROLE_VERSION : ROLE_HEADER;
        bad        = !(phase_next >= PH_BODY);
        if (last) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < held_next) begin
                    list = add(list, held_byte(2'(i)), flush_role, 4'd0);
                end
            end
        end
    end

    // token start flags follow the order of the results
    always_comb begin
        bundle       = '0;
        bundle.count = list.n;
        open_next    = open_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i) < list.n) begin
                bundle.res[i].out_byte    = list.item[i].b;
                bundle.res[i].role        = list.item[i].role;
                bundle.res[i].param_index = list.item[i].pidx;
                if (list.item[i].role == ROLE_DELIM) begin
                    open_next = 1'b0;
                end else if (list.item[i].role != ROLE_IGNORED) begin
                    bundle.res[i].token_start = !open_next;
                    open_next = 1'b1;
                end
                if (3'(i) == list.n - 3'd1) begin
                    bundle.res[i].run_last     = 1'b1;
                    bundle.res[i].message_done = last;
                    bundle.res[i].malformed    = last && bad;
                end
            end
        end
    end

    assign push.valid  = accept && (list.n != 3'd0);
    assign push.bundle = bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_METHOD;
            seg_reg   <= '0;
            inval_reg <= 1'b0;
            held_reg  <= 2'd0;
            open_reg  <= 1'b0;
        end else if (accept) begin
            if (last) begin
                phase_reg <= PH_METHOD;
                seg_reg   <= '0;
                inval_reg <= 1'b0;
                held_reg  <= 2'd0;
                open_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                seg_reg   <= seg_next;
                inval_reg <= inval_next;
                held_reg  <= held_next;
                open_reg  <= open_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/htok_queue.sv
`default_nettype none

module htok_queue
    import htok_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire htok_push_t push,
    output logic            full,
    output htok_head_t      head,
    input  wire logic       pop
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    htok_bundle_t mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full        = (count_reg == CW'(QUEUE_DEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.bundle = mem_reg[rd_ptr_reg];
    assign do_push     = push.valid && !full;
    assign do_pop      = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/htok_back.sv
`default_nettype none

module htok_back
    import htok_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire htok_head_t head,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output htok_out_t       m_data
);

    logic [1:0] sub_reg;
    logic       m_valid_reg;
    htok_out_t  m_data_reg;
    logic       load;
    logic       last_sub;

    assign load     = head.valid && (!m_valid_reg || m_ready);
    assign last_sub = ((3'(sub_reg) + 3'd1) == head.bundle.count);
    assign pop      = load && last_sub;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= head.bundle.res[sub_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                sub_reg     <= last_sub ? 2'd0 : sub_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/http_request_tokenizer_top.sv
// a byte's results are written into the bundle queue, then loaded into the output register
// throughput: one request byte per cycle while the bundle queue is not full; the output
// register sends one result per cycle while m_ready allows, so a byte that releases k results takes k transfers
// held cr/lf bytes give no result until their delimiter completes or fails, or the message ends
// reset: synchronous active-low aresetn returns the tokenizer to the method phase,
// empties the 4-entry bundle queue and drops m_valid
`default_nettype none

module http_request_tokenizer_top
    import htok_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire htok_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output htok_out_t     m_data
);

    htok_push_t push;
    htok_head_t head;
    logic       q_full;
    logic       pop;

    htok_front #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push)
    );

    htok_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    htok_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // a bundle is only written for a request that was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (s_valid && s_ready))
        else $error("bundle pushed without a request");

    // a taken request that ends the message always yields a bundle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_message) |-> push.valid)
        else $error("end of message gave no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.message_done) |-> m_data.run_last)
        else $error("message_done without run_last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.role == ROLE_DELIM || m_data.role == ROLE_IGNORED))
            |-> !m_data.token_start)
        else $error("token_start on delimiter or ignored byte");
`endif

endmodule

`default_nettype wire

// File: tb/tb_http_request_tokenizer_top.sv
import htok_pkg::*;

class htok_scoreboard;
    typedef enum {
        STG_METHOD, STG_PATH, STG_QUERY, STG_VERSION, STG_HEADER, STG_BODY
    } stage_t;

    stage_t     stage;
    logic [4:0] slot;
    bit         in_value;
    logic [1:0] held;
    bit         tok_open;
    htok_out_t  burst[$];
    htok_out_t  tokens_q[$];
    int         errors;

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        stage    = STG_METHOD;
        slot     = '0;
        in_value = 1'b0;
        held     = '0;
        tok_open = 1'b0;
    endfunction

    function int pending();
        return tokens_q.size();
    endfunction

    // position i of the cr lf cr lf terminator
    function logic [7:0] crlf_at(int i);
        return (i % 2 == 1) ? CH_LF : CH_CR;
    endfunction

    function void emit(logic [7:0] b, role_t r, logic [3:0] idx);
        htok_out_t res;
        res = '0;
        res.out_byte    = b;
        res.role        = r;
        res.param_index = idx;
        if (r == ROLE_DELIM) begin
            tok_open = 1'b0;
        end else if (r != ROLE_IGNORED) begin
            res.token_start = !tok_open;
            tok_open = 1'b1;
        end
        burst.push_back(res);
    endfunction

    function void note_request(htok_in_t req);
        logic [7:0] b;
        role_t      tail_role;
        bit         bad;
        htok_out_t  fin;
        b = req.data_byte;
        burst.delete();
        case (stage)
            STG_METHOD: begin
                if (b == CH_SPACE) begin
                    emit(b, ROLE_DELIM, 4'd0);
                    stage = STG_PATH;
                end else begin
                    emit(b, ROLE_METHOD, 4'd0);
                end
            end
            STG_PATH: begin
                if (b == CH_SPACE) begin
                    emit(b, ROLE_DELIM, 4'd0);
                    stage = STG_VERSION;
                end else if (b == CH_QMARK) begin
                    emit(b, ROLE_DELIM, 4'd0);
                    stage    = STG_QUERY;
                    slot     = '0;
                    in_value = 1'b0;
                end else begin
                    emit(b, ROLE_PATH, 4'd0);
                end
            end
            STG_QUERY: begin
                if (b == CH_SPACE) begin
                    emit(b, ROLE_DELIM, 4'd0);
                    stage = STG_VERSION;
                end else if (slot >= MAX_PARAMS_DEFAULT) begin
                    emit(b, ROLE_IGNORED, 4'd0);
                end else if (b == CH_AMP) begin
                    emit(b, ROLE_DELIM, slot[3:0]);
                    slot++;
                    in_value = 1'b0;
                end else if (b == CH_EQ && !in_value) begin
                    emit(b, ROLE_DELIM, slot[3:0]);
                    in_value = 1'b1;
                end else begin
                    emit(b, in_value ? ROLE_VALUE : ROLE_KEY, slot[3:0]);
                end
            end
            STG_VERSION: begin
                if (held != 0) begin
                    if (b == CH_LF) begin
                        emit(CH_CR, ROLE_DELIM, 4'd0);
                        emit(b, ROLE_DELIM, 4'd0);
                        held  = '0;
                        stage = STG_HEADER;
                    end else begin
                        emit(CH_CR, ROLE_VERSION, 4'd0);
                        if (b == CH_CR) begin
                            held = 2'd1;
                        end else begin
                            emit(b, ROLE_VERSION, 4'd0);
                            held = '0;
                        end
                    end
                end else if (b == CH_CR) begin
                    held = 2'd1;
                end else begin
                    emit(b, ROLE_VERSION, 4'd0);
                end
            end
            STG_HEADER: begin
                if (b == crlf_at(held)) begin
                    if (held == 2'd3) begin
                        for (int i = 0; i < 4; i++) emit(crlf_at(i), ROLE_DELIM, 4'd0);
                        held  = '0;
                        stage = STG_BODY;
                    end else begin
                        held++;
                    end
                end else begin
                    // partial terminator broken: held bytes become header text
                    for (int i = 0; i < held; i++) emit(crlf_at(i), ROLE_HEADER, 4'd0);
                    if (b == CH_CR) begin
                        held = 2'd1;
                    end else begin
                        emit(b, ROLE_HEADER, 4'd0);
                        held = '0;
                    end
                end
            end
            default: begin
                emit(b, ROLE_BODY, 4'd0);
            end
        endcase

        if (req.end_of_message) begin
            tail_role = (stage == STG_VERSION) ? ROLE_VERSION : ROLE_HEADER;
            bad = (stage != STG_BODY);
            for (int i = 0; i < held; i++) emit(crlf_at(i), tail_role, 4'd0);
            if (burst.size() > 0) begin
                fin = burst.pop_back();
                fin.run_last     = 1'b1;
                fin.message_done = 1'b1;
                fin.malformed    = bad;
                burst.push_back(fin);
            end
            reset_state();
        end else if (burst.size() > 0) begin
            fin = burst.pop_back();
            fin.run_last = 1'b1;
            burst.push_back(fin);
        end
        foreach (burst[i]) tokens_q.push_back(burst[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
        end
    endfunction

    function void check_result(htok_out_t got);
        htok_out_t want;
        if (tokens_q.size() == 0) begin
            $error("unexpected token: out_byte %0h role %0d", got.out_byte, got.role);
            errors++;
            return;
        end
        want = tokens_q.pop_front();
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("role", {4'd0, want.role}, {4'd0, got.role});
        compare_field("param_index", {4'd0, want.param_index}, {4'd0, got.param_index});
        compare_field("token_start", {7'd0, want.token_start}, {7'd0, got.token_start});
        compare_field("run_last", {7'd0, want.run_last}, {7'd0, got.run_last});
        compare_field("message_done", {7'd0, want.message_done}, {7'd0, got.message_done});
        compare_field("malformed", {7'd0, want.malformed}, {7'd0, got.malformed});
    endfunction
endclass

module tb_http_request_tokenizer_top;
    import htok_pkg::*;

    typedef logic [7:0] octet_q_t[$];

    localparam int ITEM_GOAL  = 370;
    localparam int IDLE_LIMIT = 1000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    htok_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    htok_out_t m_data;

    htok_scoreboard score;
    int             sent = 0;
    bit             calm = 1'b0;
    int             stuck_cycles = 0;

    http_request_tokenizer_top #(
        .MAX_PARAMS(MAX_PARAMS_DEFAULT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_QMARK;
            2: return CH_AMP;
            3: return CH_EQ;
            4: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] any_byte();
        if ($urandom_range(0, 3) == 0) return special_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b inside {CH_SPACE, CH_QMARK, CH_AMP, CH_EQ, CH_CR, CH_LF});
        return b;
    endfunction

    function automatic octet_q_t build_request(bit many_params);
        octet_q_t q;
        int       nseg;
        int       nlines;
        int       cut;
        // plain noise now and then
        if (!many_params && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 20)) q.push_back(any_byte());
            return q;
        end
        repeat ($urandom_range(1, 5)) q.push_back(plain_byte());
        q.push_back(CH_SPACE);
        repeat ($urandom_range(0, 5))
            q.push_back(($urandom_range(0, 2) == 0) ? 8'h2F : plain_byte());
        if (many_params || $urandom_range(0, 3) != 0) begin
            q.push_back(CH_QMARK);
            if (many_params || $urandom_range(0, 4) == 0)
                nseg = $urandom_range(MAX_PARAMS_DEFAULT + 1, MAX_PARAMS_DEFAULT + 4);
            else
                nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++) begin
                if (s != 0) q.push_back(CH_AMP);
                repeat ($urandom_range(0, 2))
                    q.push_back(($urandom_range(0, 5) == 0) ? CH_QMARK : plain_byte());
                if ($urandom_range(0, 3) != 0) begin
                    q.push_back(CH_EQ);
                    repeat ($urandom_range(0, 3))
                        q.push_back(($urandom_range(0, 5) == 0) ? CH_EQ : plain_byte());
                end
            end
        end
        q.push_back(CH_SPACE);
        repeat ($urandom_range(1, 6)) q.push_back(plain_byte());
        // stray cr inside the version
        if ($urandom_range(0, 3) == 0) begin
            q.push_back(CH_CR);
            if ($urandom_range(0, 1) == 1) q.push_back(plain_byte());
        end
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        nlines = $urandom_range(0, 3);
        repeat (nlines) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 5) == 0)
                    q.push_back(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
                else
                    q.push_back(plain_byte());
            end
            q.push_back(CH_CR);
            q.push_back(CH_LF);
        end
        if (nlines == 0) begin
            q.push_back(CH_CR);
            q.push_back(CH_LF);
        end
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        repeat ($urandom_range(0, 6)) q.push_back(any_byte());
        // truncated request
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut) void'(q.pop_back());
        end
        return q;
    endfunction

    task automatic send_request(octet_q_t bytes_q);
        htok_in_t item;
        bit       steady;
        steady = ($urandom_range(0, 3) == 0);
        foreach (bytes_q[i]) begin
            item.data_byte      = bytes_q[i];
            item.end_of_message = (i == bytes_q.size() - 1);
            s_valid <= 1'b1;
            s_data  <= item;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            score.note_request(item);
            sent++;
            if (!calm && !steady && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        while (score.pending() != 0) @(posedge aclk);
    endtask

    // result sink with random stall bursts
    initial begin
        int stall_left = 0;
        int window = 0;
        bit steady = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (window == 0) begin
                window = 64;
                steady = ($urandom_range(0, 3) == 0);
            end
            window--;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && !steady && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) score.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= IDLE_LIMIT) begin
                    $display("** http_request_tokenizer_top: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial begin
        octet_q_t msg;
        score = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // full request: extreme bytes, second '?' and '=' as text,
        // stray cr in version, broken then complete header terminator
        msg = '{8'hFF, CH_SPACE, "/", CH_QMARK, "k", CH_EQ, CH_EQ, CH_AMP, CH_QMARK,
                CH_SPACE, CH_CR, CH_CR, CH_LF, CH_CR, CH_LF, 8'h7F, CH_CR, CH_LF,
                CH_CR, CH_LF, 8'h01};
        send_request(msg);
        // ends with a held cr in the version: flushed, malformed
        msg = '{"A", CH_SPACE, "B", CH_SPACE, CH_CR};
        send_request(msg);
        // single-byte request
        msg = '{8'h80};
        send_request(msg);

        s_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);

        send_request(build_request(1'b1));
        while (sent < ITEM_GOAL) begin
            calm = (sent >= ITEM_GOAL - 50);
            send_request(build_request(1'b0));
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);
        if (score.errors == 0 && score.pending() == 0) begin
            $display("** http_request_tokenizer_top: PASSED **");
        end else begin
            $display("** http_request_tokenizer_top: FAILED **");
        end
        $finish;
    end
endmodule
